>>> hdl/merkle_proof_verifier_defines.svh
// assertion macros for the merkle proof verifier
`ifndef MERKLE_PROOF_VERIFIER_DEFINES_SVH
`define MERKLE_PROOF_VERIFIER_DEFINES_SVH
`ifndef SYNTH
`define MPV_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("mpv check failed");
`define MPV_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("mpv check failed");
`else
`define MPV_ASSERT_IMP(label, clk, rst_n, a, c)
`define MPV_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/mpv_pkg.sv
// shared constants, round table and functions for the merkle proof verifier
`timescale 1ns / 1ps
package mpv_pkg;
    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_COMBINE = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;
    localparam int ROUNDS = 64;
    localparam logic [31:0] MSG_BITS = 32'd512;

    typedef logic [31:0] t_word;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic t_word round_k(input logic [5:0] t);
        t_word k [64];
        k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

>>> hdl/merkle_proof_verifier.sv
// merkle proof verifier top level: stream control and one sha-256 round unit
//  channel | dir | tdata (low bit up)                              | tuser
//  s_axis  | in  | data_word_0..3 (256 bits)                         | operation, is_right
//  m_axis  | out | node_word_0..3 (256 bits)                         | root_match
// begin and finish are taken without the round unit; after a combine word is taken, tready
// stays low through two compressions of 64 rounds on the single round unit, each
// followed by a fold step, before the next word can be taken.
// finish loads the output register; no word is taken while a result waits.
// reset (synchronous, active low) clears the node, round counter and control.
`timescale 1ns / 1ps
`include "merkle_proof_verifier_defines.svh"
module merkle_proof_verifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // data_word_0, data_word_1, data_word_2, data_word_3
    input  logic [7:0]   s_axis_tuser,  // operation[1:0], is_right[2], zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata,  // node_word_0, node_word_1, node_word_2, node_word_3
    output logic         m_axis_tuser   // root_match
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_FOLD  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [6:0]          r_round;
    logic                r_phase;
    logic [255:0]        r_node;
    mpv_pkg::t_word      r_cv [8];
    mpv_pkg::t_word      r_v  [8];
    mpv_pkg::t_word      r_w  [16];
    logic                r_oval;
    logic [255:0]        r_odata;
    logic                r_omatch;

    logic [1:0]   in_op;
    logic         in_right;
    logic         take;
    logic [63:0]  dw [4];
    assign in_op    = s_axis_tuser[1:0];
    assign in_right = s_axis_tuser[2];
    assign s_axis_tready = (r_state == S_IDLE) && !r_oval;
    assign take = s_axis_tvalid && s_axis_tready;
    always_comb begin
        for (int i = 0; i < 4; i++) dw[i] = s_axis_tdata[64*i +: 64];
    end

    // schedule word and round datapath
    logic [3:0]     t15, t2, t7, tc;
    mpv_pkg::t_word w_new, w_cur, s1, ch, t1, s0, mj;
    always_comb begin
        tc  = r_round[3:0];
        t15 = r_round[3:0] - 4'd15;
        t2  = r_round[3:0] - 4'd2;
        t7  = r_round[3:0] - 4'd7;
        w_new = r_w[tc] + r_w[t7]
              + (mpv_pkg::rotr(r_w[t15], 7) ^ mpv_pkg::rotr(r_w[t15], 18) ^ (r_w[t15] >> 3))
              + (mpv_pkg::rotr(r_w[t2], 17) ^ mpv_pkg::rotr(r_w[t2], 19) ^ (r_w[t2] >> 10));
        w_cur = (r_round < 7'd16) ? r_w[tc] : w_new;
        s1 = mpv_pkg::rotr(r_v[4], 6) ^ mpv_pkg::rotr(r_v[4], 11) ^ mpv_pkg::rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + mpv_pkg::round_k(r_round[5:0]) + w_cur;
        s0 = mpv_pkg::rotr(r_v[0], 2) ^ mpv_pkg::rotr(r_v[0], 13) ^ mpv_pkg::rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (take && in_op == mpv_pkg::OP_COMBINE) n_state = S_ROUND;
            S_ROUND: if (r_round == 7'(mpv_pkg::ROUNDS - 1)) n_state = S_FOLD;
            S_FOLD:  n_state = r_phase ? S_IDLE : S_ROUND;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_phase <= 1'b0;
            r_node  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_oval && m_axis_tready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take && in_op == mpv_pkg::OP_BEGIN) r_node <= s_axis_tdata;
                    if (take && in_op == mpv_pkg::OP_FINISH) r_oval <= 1'b1;
                    r_round <= '0;
                    r_phase <= 1'b0;
                end
                S_ROUND: r_round <= (r_round == 7'(mpv_pkg::ROUNDS - 1)) ? 7'd0 : r_round + 7'd1;
                S_FOLD: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        for (int i = 0; i < 4; i++)
                            r_node[64*i +: 64] <= {r_cv[2*i] + r_v[2*i],
                                                   r_cv[2*i+1] + r_v[2*i+1]};
                    end
                end
                default: ;
            endcase
        end
    end

    // hash state: load, rounds and fold
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (take && in_op == mpv_pkg::OP_COMBINE) begin
                    for (int i = 0; i < 8; i++) begin
                        r_cv[i] <= mpv_pkg::IV[i];
                        r_v[i]  <= mpv_pkg::IV[i];
                    end
                    for (int i = 0; i < 4; i++) begin
                        r_w[2*i]     <= in_right ? dw[i][63:32] : r_node[64*i+32 +: 32];
                        r_w[2*i+1]   <= in_right ? dw[i][31:0]  : r_node[64*i +: 32];
                        r_w[8+2*i]   <= in_right ? r_node[64*i+32 +: 32] : dw[i][63:32];
                        r_w[8+2*i+1] <= in_right ? r_node[64*i +: 32]    : dw[i][31:0];
                    end
                end
                if (take && in_op == mpv_pkg::OP_FINISH) begin
                    r_odata  <= r_node;
                    r_omatch <= (r_node == s_axis_tdata);
                end
            end
            S_ROUND: begin
                if (r_round >= 7'd16) r_w[tc] <= w_new;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + s0 + mj;
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    r_cv[i] <= r_cv[i] + r_v[i];
                    r_v[i]  <= r_cv[i] + r_v[i];
                end
                // padding block: leading one bit, zeros, message length
                for (int i = 1; i < 15; i++) r_w[i] <= '0;
                r_w[0]  <= 32'h80000000;
                r_w[15] <= mpv_pkg::MSG_BITS;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_omatch;

    // checks
    `MPV_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `MPV_ASSERT_NXT(a_round_step, i_clk, i_rst_n, r_state == S_ROUND && r_round != 7'd63, r_round == $past(r_round) + 7'd1)
    `MPV_ASSERT_IMP(a_idle_round_zero, i_clk, i_rst_n, r_state == S_IDLE, r_round == 7'd0)
endmodule
